FILE: src/pr_pkg.sv
`default_nettype none
package pr_pkg;

    // Default configuration
    localparam int ROTATION_STEPS_DEF = 16;
    localparam int FRACTION_BITS_DEF  = 16;

    // Datapath widths: coordinates carry 24 guard bits, angle is Q30 radians
    localparam int GUARD_BITS = 24;
    localparam int XY_W       = 59;
    localparam int Z_W        = 33;

    // 1/(2 pi) in Q64, pi/2 in Q30, inverse CORDIC gain in Q30
    localparam logic [63:0] INV_TWO_PI_Q64  = 64'h28BE_60DB_9391_054A;
    localparam logic signed [31:0] HALF_PI_Q30 = 32'sd1686629713;
    localparam longint GAIN_INV_Q30    = 64'd652032874;
    localparam longint GAIN_TWO_THIRDS = (GAIN_INV_Q30 * 2) / 3;

    typedef struct packed {
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic signed [Z_W-1:0]  z;
    } pr_vec_t;

    // Arctangent of 2^-i in Q30 radians
    function automatic logic signed [Z_W-1:0] pr_atan(input int i);
        logic signed [Z_W-1:0] a;
        case (i)
            0:  a = 33'sd843314857;
            1:  a = 33'sd497837829;
            2:  a = 33'sd263043837;
            3:  a = 33'sd133525159;
            4:  a = 33'sd67021687;
            5:  a = 33'sd33543516;
            6:  a = 33'sd16775851;
            7:  a = 33'sd8388437;
            8:  a = 33'sd4194283;
            9:  a = 33'sd2097149;
            10: a = 33'sd1048576;
            11: a = 33'sd524288;
            12: a = 33'sd262144;
            13: a = 33'sd131072;
            14: a = 33'sd65536;
            15: a = 33'sd32768;
            16: a = 33'sd16384;
            17: a = 33'sd8192;
            18: a = 33'sd4096;
            19: a = 33'sd2048;
            20: a = 33'sd1024;
            21: a = 33'sd512;
            22: a = 33'sd256;
            23: a = 33'sd128;
            24: a = 33'sd64;
            25: a = 33'sd32;
            26: a = 33'sd16;
            27: a = 33'sd8;
            28: a = 33'sd4;
            29: a = 33'sd2;
            default: a = '0;
        endcase
        return a;
    endfunction

endpackage
`default_nettype wire

FILE: src/pr_front.sv
`default_nettype none
module pr_front #(
    parameter int ROTATION_STEPS = pr_pkg::ROTATION_STEPS_DEF,
    parameter int FRACTION_BITS  = pr_pkg::FRACTION_BITS_DEF
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic signed [31:0] s_point_x,
    input  wire logic signed [31:0] s_point_y,
    input  wire logic signed [31:0] s_turn_angle,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output pr_pkg::pr_vec_t         out_vec
);
    import pr_pkg::*;

    localparam longint GAIN_L = GAIN_INV_Q30 + (GAIN_TWO_THIRDS >>> (2 * ROTATION_STEPS));
    localparam logic signed [32:0] GAIN = 33'(GAIN_L);
    localparam logic [31:0] K_LO = INV_TWO_PI_Q64[31:0];
    localparam logic [31:0] K_HI = INV_TWO_PI_Q64[63:32];
    localparam logic signed [62:0] Z_HALF  = 63'sd536870912;
    localparam logic signed [65:0] XY_HALF = 66'sd32;

    logic [4:0] v_reg;
    logic [4:0] rdy;

    // stage 1: |angle| times 1/(2 pi), two partial products
    logic [31:0] mag;
    logic [63:0] plo_reg, phi_reg;
    logic        neg1_reg;
    logic signed [31:0] px1_reg, py1_reg;

    // stage 2: phase
    logic [63:0] mid;
    logic [31:0] ph_raw;
    logic [31:0] ph2_reg;
    logic signed [31:0] px2_reg, py2_reg;

    // stage 3: quadrant split and swap
    logic [31:0] shifted;
    logic signed [32:0] ex, ey, qx_next, qy_next;
    logic signed [32:0] qx3_reg, qy3_reg;
    logic signed [30:0] resid_next, resid3_reg;

    // stage 4: scale residual angle and gain precompensation
    logic signed [62:0] zp4_reg;
    logic signed [65:0] xp4_reg, yp4_reg;

    // stage 5: round into CORDIC formats
    pr_vec_t vec5_reg;

    // advance a stage when it is empty or its successor takes its request
    assign rdy[4] = !v_reg[4] || out_ready;
    assign rdy[3] = !v_reg[3] || rdy[4];
    assign rdy[2] = !v_reg[2] || rdy[3];
    assign rdy[1] = !v_reg[1] || rdy[2];
    assign rdy[0] = !v_reg[0] || rdy[1];
    assign s_ready   = rdy[0];
    assign out_valid = v_reg[4];
    assign out_vec   = vec5_reg;

    assign mag    = s_turn_angle[31] ? (~s_turn_angle + 32'd1) : s_turn_angle;
    assign mid    = phi_reg + {32'd0, plo_reg[63:32]};
    assign ph_raw = mid[FRACTION_BITS +: 32];

    assign shifted    = ph2_reg + 32'h2000_0000;
    assign resid_next = $signed({1'b0, shifted[29:0]}) - 31'sd536870912;
    assign ex = 33'(px2_reg);
    assign ey = 33'(py2_reg);

    // apply whole quarter turns exactly
    always_comb begin
        case (shifted[31:30])
            2'd1: begin
                qx_next = -ey;
                qy_next = ex;
            end
            2'd2: begin
                qx_next = -ex;
                qy_next = -ey;
            end
            2'd3: begin
                qx_next = ey;
                qy_next = -ex;
            end
            default: begin
                qx_next = ex;
                qy_next = ey;
            end
        endcase
    end

    // valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            if (rdy[0]) v_reg[0] <= s_valid;
            if (rdy[1]) v_reg[1] <= v_reg[0];
            if (rdy[2]) v_reg[2] <= v_reg[1];
            if (rdy[3]) v_reg[3] <= v_reg[2];
            if (rdy[4]) v_reg[4] <= v_reg[3];
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (rdy[0]) begin
            plo_reg  <= 64'(mag) * 64'(K_LO);
            phi_reg  <= 64'(mag) * 64'(K_HI);
            neg1_reg <= s_turn_angle[31];
            px1_reg  <= s_point_x;
            py1_reg  <= s_point_y;
        end
        if (rdy[1]) begin
            ph2_reg <= neg1_reg ? (32'd0 - ph_raw) : ph_raw;
            px2_reg <= px1_reg;
            py2_reg <= py1_reg;
        end
        if (rdy[2]) begin
            qx3_reg    <= qx_next;
            qy3_reg    <= qy_next;
            resid3_reg <= resid_next;
        end
        if (rdy[3]) begin
            zp4_reg <= resid3_reg * HALF_PI_Q30;
            xp4_reg <= qx3_reg * GAIN;
            yp4_reg <= qy3_reg * GAIN;
        end
        if (rdy[4]) begin
            vec5_reg.z <= Z_W'((zp4_reg + Z_HALF) >>> 30);
            vec5_reg.x <= XY_W'((xp4_reg + XY_HALF) >>> (30 - GUARD_BITS));
            vec5_reg.y <= XY_W'((yp4_reg + XY_HALF) >>> (30 - GUARD_BITS));
        end
    end

endmodule
`default_nettype wire

FILE: src/pr_cell.sv
`default_nettype none
module pr_cell #(
    parameter int STEP = 0
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         in_valid,
    output logic              in_ready,
    input  wire pr_pkg::pr_vec_t in_vec,
    output logic              out_valid,
    input  wire logic         out_ready,
    output pr_pkg::pr_vec_t   out_vec
);
    import pr_pkg::*;

    localparam logic signed [Z_W-1:0] ATAN = pr_atan(STEP);

    logic    valid_reg;
    pr_vec_t vec_reg, vec_next;
    logic signed [XY_W-1:0] dx, dy;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_vec   = vec_reg;

    assign dx = in_vec.y >>> STEP;
    assign dy = in_vec.x >>> STEP;

    // rotate toward zero residual angle
    always_comb begin
        if (!in_vec.z[Z_W-1]) begin
            vec_next.x = in_vec.x - dx;
            vec_next.y = in_vec.y + dy;
            vec_next.z = in_vec.z - ATAN;
        end else begin
            vec_next.x = in_vec.x + dx;
            vec_next.y = in_vec.y - dy;
            vec_next.z = in_vec.z + ATAN;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready) begin
            vec_reg <= vec_next;
        end
    end

endmodule
`default_nettype wire

FILE: src/pr_out.sv
`default_nettype none
module pr_out (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         in_valid,
    output logic              in_ready,
    input  wire pr_pkg::pr_vec_t in_vec,
    output logic              m_valid,
    input  wire logic         m_ready,
    output logic signed [31:0] m_rotated_x,
    output logic signed [31:0] m_rotated_y,
    output logic              m_saturated
);
    import pr_pkg::*;

    localparam logic signed [XY_W-1:0] MAX_V = XY_W'(64'sd2147483647);
    localparam logic signed [XY_W-1:0] MIN_V = ~MAX_V;
    localparam logic signed [XY_W-1:0] HALF  = XY_W'(64'sd1 <<< (GUARD_BITS - 1));

    logic valid_reg;
    logic signed [XY_W-1:0] rx, ry;
    logic signed [31:0] cx, cy;
    logic sat_x, sat_y;
    logic signed [31:0] x_reg, y_reg;
    logic sat_reg;

    assign in_ready    = !valid_reg || m_ready;
    assign m_valid     = valid_reg;
    assign m_rotated_x = x_reg;
    assign m_rotated_y = y_reg;
    assign m_saturated = sat_reg;

    // drop guard bits with round to nearest
    assign rx = (in_vec.x + HALF) >>> GUARD_BITS;
    assign ry = (in_vec.y + HALF) >>> GUARD_BITS;

    // clip to the 32-bit range
    always_comb begin
        sat_x = 1'b1;
        sat_y = 1'b1;
        if (rx > MAX_V) begin
            cx = 32'sh7FFF_FFFF;
        end else if (rx < MIN_V) begin
            cx = 32'sh8000_0000;
        end else begin
            cx = rx[31:0];
            sat_x = 1'b0;
        end
        if (ry > MAX_V) begin
            cy = 32'sh7FFF_FFFF;
        end else if (ry < MIN_V) begin
            cy = 32'sh8000_0000;
        end else begin
            cy = ry[31:0];
            sat_y = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready) begin
            x_reg   <= cx;
            y_reg   <= cy;
            sat_reg <= sat_x || sat_y;
        end
    end

endmodule
`default_nettype wire

FILE: src/point_rotator_unit.sv
// Stages from request accept to result valid: five front stages for angle reduction
//   and prescale, one cell per CORDIC step, one rounding and saturation stage.
// Throughput: one request per cycle; each stage stalls only when it is full and its
//   successor is stalled. Reset clears the valid bits of every stage.
`default_nettype none
module point_rotator_unit #(
    parameter int ROTATION_STEPS = pr_pkg::ROTATION_STEPS_DEF,
    parameter int FRACTION_BITS  = pr_pkg::FRACTION_BITS_DEF
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic signed [31:0] s_point_x,
    input  wire logic signed [31:0] s_point_y,
    input  wire logic signed [31:0] s_turn_angle,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic signed [31:0]      m_rotated_x,
    output logic signed [31:0]      m_rotated_y,
    output logic                    m_saturated
);
    import pr_pkg::*;

    logic    chain_valid [ROTATION_STEPS+1];
    logic    chain_ready [ROTATION_STEPS+1];
    pr_vec_t chain_vec   [ROTATION_STEPS+1];

    // angle reduction, quadrant swap and gain prescale
    pr_front #(
        .ROTATION_STEPS (ROTATION_STEPS),
        .FRACTION_BITS  (FRACTION_BITS)
    ) u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_point_x    (s_point_x),
        .s_point_y    (s_point_y),
        .s_turn_angle (s_turn_angle),
        .out_valid    (chain_valid[0]),
        .out_ready    (chain_ready[0]),
        .out_vec      (chain_vec[0])
    );

    // one micro-rotation per cell
    for (genvar i = 0; i < ROTATION_STEPS; i++) begin : g_cell
        pr_cell #(
            .STEP (i)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (chain_valid[i]),
            .in_ready  (chain_ready[i]),
            .in_vec    (chain_vec[i]),
            .out_valid (chain_valid[i+1]),
            .out_ready (chain_ready[i+1]),
            .out_vec   (chain_vec[i+1])
        );
    end

    // round, saturate and hold the result
    pr_out u_out (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (chain_valid[ROTATION_STEPS]),
        .in_ready    (chain_ready[ROTATION_STEPS]),
        .in_vec      (chain_vec[ROTATION_STEPS]),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_rotated_x (m_rotated_x),
        .m_rotated_y (m_rotated_y),
        .m_saturated (m_saturated)
    );

    // a saturated result sits on a range limit
    a_sat_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_saturated) |->
            (m_rotated_x == 32'sh7FFF_FFFF || m_rotated_x == 32'sh8000_0000 ||
             m_rotated_y == 32'sh7FFF_FFFF || m_rotated_y == 32'sh8000_0000))
        else $error("saturated flag without clipped coordinate");

    // a request leaving the last cell lands in the output register
    a_chain_to_out: assert property (@(posedge aclk) disable iff (!aresetn)
        (chain_valid[ROTATION_STEPS] && chain_ready[ROTATION_STEPS]) |=> m_valid)
        else $error("request lost between last cell and output");

    // an empty output register never blocks the input side of the chain
    a_out_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> chain_ready[ROTATION_STEPS])
        else $error("output stage stalls while empty");

endmodule
`default_nettype wire

FILE: tb/point_rotator_unit_test.sv
module point_rotator_unit_test;

    // Build parameters of the instance (the defaults)
    localparam int STEPS     = 16;
    localparam int FRAC_BITS = 16;
    localparam int GUARD     = 24;

    // Angle reduction and CORDIC constants
    localparam logic [63:0] RECIP_TWO_PI_Q64 = 64'h28BE_60DB_9391_054A;
    localparam longint QUARTER_TURN_Q30     = 64'sd1686629713;
    localparam longint CORDIC_GAIN_INV_Q30  = 64'sd652032874;
    localparam longint COORD_MAX            = 64'sh0000_0000_7FFF_FFFF;
    localparam longint COORD_MIN            = -COORD_MAX - 64'sd1;

    // Angles in 16.16 radians
    localparam logic signed [31:0] ANGLE_QUARTER_PI = 32'sd51472;
    localparam logic signed [31:0] ANGLE_HALF_PI    = 32'sd102944;
    localparam logic signed [31:0] ANGLE_PI         = 32'sd205887;
    localparam logic signed [31:0] ANGLE_3HALF_PI   = 32'sd308831;
    localparam logic signed [31:0] ANGLE_TWO_PI     = 32'sd411775;
    localparam logic signed [31:0] UNIT             = 32'sd65536;
    localparam logic signed [31:0] WORD_MAX         = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] WORD_MIN         = 32'sh8000_0000;

    localparam int LATENCY     = 6 + STEPS;
    localparam int CYCLE_LIMIT = 300000;
    localparam int REPORT_MAX  = 10;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic               sat;
    } rotated_point_t;

    typedef enum logic [1:0] {
        SRC_STEADY,
        SRC_BURSTY,
        SRC_SPARSE
    } source_mode_t;

    typedef enum logic [1:0] {
        SINK_OPEN,
        SINK_RANDOM,
        SINK_PATTERN,
        SINK_CHOKED
    } sink_mode_t;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic signed [31:0] s_point_x = '0;
    logic signed [31:0] s_point_y = '0;
    logic signed [31:0] s_turn_angle = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic signed [31:0] m_rotated_x;
    logic signed [31:0] m_rotated_y;
    logic               m_saturated;

    rotated_point_t pending_points[$];
    source_mode_t   source_mode = SRC_STEADY;
    sink_mode_t     sink_mode = SINK_OPEN;
    int             burst_left = 0;
    int             sink_phase = 0;
    int             fault_count = 0;
    int             cycle_count = 0;

    point_rotator_unit dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_point_x    (s_point_x),
        .s_point_y    (s_point_y),
        .s_turn_angle (s_turn_angle),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_rotated_x  (m_rotated_x),
        .m_rotated_y  (m_rotated_y),
        .m_saturated  (m_saturated)
    );

    always #5 aclk = ~aclk;

    // Arctangent of 2^-i in Q30 radians
    function automatic longint micro_angle(input int i);
        case (i)
            0:  return 843314857;
            1:  return 497837829;
            2:  return 263043837;
            3:  return 133525159;
            4:  return 67021687;
            5:  return 33543516;
            6:  return 16775851;
            7:  return 8388437;
            8:  return 4194283;
            9:  return 2097149;
            default: return longint'(1) << (30 - i);
        endcase
    endfunction

    function automatic longint round_shift(input longint v, input int s);
        return (v + (longint'(1) << (s - 1))) >>> s;
    endfunction

    // Clip to the 32-bit range; the top bit flags a clip
    function automatic logic [32:0] clamp_coord(input longint v);
        if (v > COORD_MAX)
            return {1'b1, 32'h7FFF_FFFF};
        if (v < COORD_MIN)
            return {1'b1, 32'h8000_0000};
        return {1'b0, v[31:0]};
    endfunction

    // Rotate (px, py) counterclockwise by ang radians
    function automatic rotated_point_t predict_rotation(input logic signed [31:0] px,
                                                        input logic signed [31:0] py,
                                                        input logic signed [31:0] ang);
        longint         a;
        logic [63:0]    mag;
        logic [63:0]    lo_prod;
        logic [63:0]    mid;
        logic [31:0]    phase;
        logic [31:0]    shifted;
        longint         resid;
        longint         z;
        longint         x;
        longint         y;
        longint         t;
        longint         dx;
        longint         dy;
        longint         gain;
        logic [32:0]    cx;
        logic [32:0]    cy;
        rotated_point_t r;
        a = ang;
        mag = (a < 0) ? -a : a;
        // Phase of the angle: a full turn is 2^32
        lo_prod = mag * {32'b0, RECIP_TWO_PI_Q64[31:0]};
        mid = mag * {32'b0, RECIP_TWO_PI_Q64[63:32]} + (lo_prod >> 32);
        phase = mid[FRAC_BITS +: 32];
        if (a < 0)
            phase = 32'd0 - phase;
        // Split into a quarter turn and a residue in [-pi/4, pi/4)
        shifted = phase + 32'h2000_0000;
        resid = longint'(shifted[29:0]) - 64'sd536870912;
        z = round_shift(resid * QUARTER_TURN_Q30, 30);
        case (shifted[31:30])
            2'd1: begin
                x = -longint'(py);
                y = px;
            end
            2'd2: begin
                x = -longint'(px);
                y = -longint'(py);
            end
            2'd3: begin
                x = py;
                y = -longint'(px);
            end
            default: begin
                x = px;
                y = py;
            end
        endcase
        // Prescale by the inverse gain into the guard-bit datapath
        gain = CORDIC_GAIN_INV_Q30 + ((CORDIC_GAIN_INV_Q30 * 2 / 3) >>> (2 * STEPS));
        x = round_shift(x * gain, 30 - GUARD);
        y = round_shift(y * gain, 30 - GUARD);
        for (int i = 0; i < STEPS && i < 30; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                t = x - dx;
                y = y + dy;
                x = t;
                z = z - micro_angle(i);
            end else begin
                t = x + dx;
                y = y - dy;
                x = t;
                z = z + micro_angle(i);
            end
        end
        cx = clamp_coord(round_shift(x, GUARD));
        cy = clamp_coord(round_shift(y, GUARD));
        r.x = cx[31:0];
        r.y = cy[31:0];
        r.sat = cx[32] | cy[32];
        return r;
    endfunction

    // Present one request, hold it until accepted, then queue its rotation
    task automatic send_point(input logic signed [31:0] px,
                              input logic signed [31:0] py,
                              input logic signed [31:0] ang);
        int gap;
        gap = 0;
        if (burst_left <= 0) begin
            case (source_mode)
                SRC_BURSTY: begin
                    gap = $urandom_range(0, 5);
                    burst_left = $urandom_range(1, 8);
                end
                SRC_SPARSE: begin
                    gap = $urandom_range(1, 10);
                    burst_left = $urandom_range(1, 2);
                end
                default: burst_left = 1;
            endcase
            if (gap > 0) begin
                s_valid = 1'b0;
                repeat (gap) @(negedge aclk);
            end
        end
        s_valid = 1'b1;
        s_point_x = px;
        s_point_y = py;
        s_turn_angle = ang;
        do @(posedge aclk); while (!s_ready);
        pending_points.push_back(predict_rotation(px, py, ang));
        burst_left--;
        @(negedge aclk);
    endtask

    function automatic logic signed [31:0] rand_coord();
        logic signed [31:0] v;
        v = $urandom();
        return v >>> $urandom_range(0, 31);
    endfunction

    // Drive the receiver's ready on the selected stall pattern
    always @(negedge aclk) begin
        sink_phase <= (sink_phase + 1) % 7;
        case (sink_mode)
            SINK_RANDOM:  m_ready <= ($urandom_range(0, 3) != 0);
            SINK_PATTERN: m_ready <= 1'(7'b1101001 >> sink_phase);
            SINK_CHOKED:  m_ready <= ($urandom_range(0, 5) == 0);
            default:      m_ready <= 1'b1;
        endcase
    end

    // Compare each result with the oldest pending rotation
    always @(posedge aclk) begin : check_results
        rotated_point_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_points.size() == 0) begin
                fault_count++;
                if (fault_count <= REPORT_MAX)
                    $display("unexpected result x=%0d y=%0d sat=%0b",
                             m_rotated_x, m_rotated_y, m_saturated);
            end else begin
                want = pending_points.pop_front();
                if (m_rotated_x !== want.x || m_rotated_y !== want.y
                        || m_saturated !== want.sat) begin
                    fault_count++;
                    if (fault_count <= REPORT_MAX)
                        $display("mismatch: expected x=%0d y=%0d sat=%0b, got x=%0d y=%0d sat=%0b",
                                 want.x, want.y, want.sat,
                                 m_rotated_x, m_rotated_y, m_saturated);
                end
            end
        end
    end

    // Stop a hung run
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Origin, extreme coordinates and angles, quarter turns, clipping
    task automatic test_directed_corners();
        source_mode = SRC_STEADY;
        sink_mode = SINK_OPEN;
        send_point(0, 0, 0);
        send_point(0, 0, ANGLE_PI);
        send_point(0, 0, WORD_MIN);
        send_point(UNIT, 0, 0);
        send_point(UNIT, 0, ANGLE_HALF_PI);
        send_point(UNIT, 0, ANGLE_PI);
        send_point(UNIT, 0, ANGLE_3HALF_PI);
        send_point(UNIT, 0, -ANGLE_HALF_PI);
        send_point(UNIT, 0, ANGLE_TWO_PI);
        send_point(UNIT, UNIT, 32'sd1);
        send_point(UNIT, UNIT, -32'sd1);
        send_point(-32'sd1, -32'sd1, -ANGLE_PI);
        send_point(32'sd1, 32'sd0, ANGLE_QUARTER_PI);
        send_point(WORD_MAX, WORD_MAX, 0);
        send_point(WORD_MAX, WORD_MAX, ANGLE_QUARTER_PI);
        send_point(WORD_MIN, WORD_MIN, ANGLE_PI);
        send_point(WORD_MIN, WORD_MIN, -ANGLE_QUARTER_PI);
        send_point(WORD_MIN, 0, ANGLE_HALF_PI);
        send_point(0, WORD_MIN, ANGLE_3HALF_PI);
        send_point(WORD_MAX, WORD_MIN, WORD_MAX);
        send_point(WORD_MIN, WORD_MAX, WORD_MIN);
        send_point(WORD_MAX, 0, -ANGLE_PI);
        send_point(-UNIT, UNIT, 32'sh4000_0000);
    endtask

    // Full-range random requests with bursty flow on both sides
    task automatic test_random_full_range(input int count);
        source_mode = SRC_BURSTY;
        sink_mode = SINK_RANDOM;
        repeat (count)
            send_point($urandom(), $urandom(), $urandom());
    endtask

    // Coordinates of every magnitude, angles within a few turns
    task automatic test_random_scaled(input int count);
        source_mode = SRC_SPARSE;
        sink_mode = SINK_PATTERN;
        repeat (count)
            send_point(rand_coord(), rand_coord(),
                       $urandom_range(0, 8 * ANGLE_TWO_PI) - 4 * ANGLE_TWO_PI);
    endtask

    // Angles a few steps off each quarter turn; first unthrottled, then choked
    task automatic test_quadrant_edges(input int count);
        int k;
        source_mode = SRC_STEADY;
        sink_mode = SINK_OPEN;
        for (int n = 0; n < count; n++) begin
            if (n == count / 2)
                sink_mode = SINK_CHOKED;
            k = $urandom_range(0, 16);
            send_point(rand_coord(), rand_coord(),
                       (k - 8) * ANGLE_HALF_PI + $urandom_range(0, 8) - 4);
        end
    endtask

    initial begin
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_directed_corners();
        test_random_full_range(250);
        test_random_scaled(200);
        test_quadrant_edges(200);

        // Drain the pipeline, then watch for stray results
        s_valid = 1'b0;
        sink_mode = SINK_OPEN;
        while (pending_points.size() != 0)
            @(posedge aclk);
        repeat (LATENCY + 10) @(posedge aclk);
        if (fault_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

FILE: sim.f
src/pr_pkg.sv
src/pr_front.sv
src/pr_cell.sv
src/pr_out.sv
src/point_rotator_unit.sv
tb/point_rotator_unit_test.sv
